// File: hw/rtl/inrt_pkg.sv
// Shared types and constants for the indentation nesting range tracker.
package inrt_pkg;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_WS_LAST = 8'd13;

   localparam int TAB_BITS   = 5;
   localparam int POS_BITS   = 17;
   localparam int GUIDE_BITS = 12;

   localparam logic [TAB_BITS-1:0] TAB_RESET = 5'd4;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       has_char;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   range_start;
      logic [POS_BITS-1:0]   range_end;
      logic [GUIDE_BITS-1:0] guide_level;
      logic                  is_end_marker;
      logic                  overflow;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   range_start;
      logic [POS_BITS-1:0]   range_end;
      logic [GUIDE_BITS-1:0] guide_level;
   } range_type;

   typedef struct packed {
      logic emit;
      logic finish;
      logic end_text;
      logic overflow;
   } emit_ctl_type;

   typedef struct packed {
      logic pend_valid;
      logic out_free;
   } stage_sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_RD,
      ST_POP_CMP,
      ST_PUSH,
      ST_FLUSH_RD,
      ST_FLUSH_CMP,
      ST_DONE
   } state_type;

endpackage

// File: hw/rtl/inrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module inrt_ram
   #(parameter int WIDTH = 8,
     parameter int DEPTH = 16)
   (input  logic                     clock,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/inrt_out_stage.sv
// Result holding stage: one pending range plus the output register.
module inrt_out_stage
   import inrt_pkg::*;
   (input  logic          clock,
    input  logic          reset,
    input  emit_ctl_type  ctl,
    input  range_type     range_in,
    output stage_sts_type sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rsp_type       rsp_data);

   range_type pend_ff, pend_in;
   logic      pend_valid_ff, pend_valid_in;
   rsp_type   out_ff, out_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.out_free = out_free;

   always_comb begin
      pend_in = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (ctl.emit) begin
         if (pend_valid_ff) begin
            out_in.range_start = pend_ff.range_start;
            out_in.range_end = pend_ff.range_end;
            out_in.guide_level = pend_ff.guide_level;
            out_in.is_end_marker = 1'b0;
            out_in.overflow = ctl.overflow;
            out_in.last_of_run = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in = range_in;
         pend_valid_in = 1'b1;
      end else if (ctl.finish) begin
         if (pend_valid_ff) begin
            out_in.range_start = pend_ff.range_start;
            out_in.range_end = pend_ff.range_end;
            out_in.guide_level = pend_ff.guide_level;
            out_in.is_end_marker = ctl.end_text;
            out_in.overflow = ctl.overflow;
            out_in.last_of_run = 1'b1;
            out_valid_in = 1'b1;
         end else if (ctl.end_text) begin
            out_in = '0;
            out_in.is_end_marker = 1'b1;
            out_in.overflow = ctl.overflow;
            out_in.last_of_run = 1'b1;
            out_valid_in = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

endmodule

// File: hw/rtl/inrt_core.sv
// Line scanner and stack sequencer; the stack lives in an external RAM.
module inrt_core
   import inrt_pkg::*;
   #(parameter int STACK_DEPTH = 32,
     parameter int MAX_LINES = 65536,
     parameter int LEVEL_BITS = 12,
     localparam int LINE_BITS = $clog2(MAX_LINES),
     localparam int ADDR_BITS = $clog2(STACK_DEPTH),
     localparam int ENTRY_BITS = LEVEL_BITS + LINE_BITS)
   (input  logic                  clock,
    input  logic                  reset,
    input  logic                  csr_we,
    input  logic [TAB_BITS-1:0]   csr_wdata,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_type               req_data,
    output logic                  ram_wr_en,
    output logic [ADDR_BITS-1:0]  ram_wr_addr,
    output logic [ENTRY_BITS-1:0] ram_wr_data,
    output logic                  ram_rd_en,
    output logic [ADDR_BITS-1:0]  ram_rd_addr,
    input  logic [ENTRY_BITS-1:0] ram_rd_data,
    output emit_ctl_type          ctl,
    output range_type             range_out,
    input  stage_sts_type         sts);

   localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
   localparam int SUM_BITS = LEVEL_BITS + 5;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
   localparam logic [LINE_BITS-1:0] LINE_LAST = LINE_BITS'(MAX_LINES - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(STACK_DEPTH);

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [LEVEL_BITS-1:0] indent_ff, indent_in;
   logic                  leading_ff, leading_in;
   logic                  nonblank_ff, nonblank_in;
   logic                  ovf_ff, ovf_in;
   logic [TAB_BITS-1:0]   tab_ff;
   logic                  eot_ff, eot_in;
   logic                  nl_ff, nl_in;

   logic                  accept, is_nl, is_ws, take, close, nb_now;
   logic [LEVEL_BITS-1:0] byte_indent;
   logic                  byte_leading;
   logic [SUM_BITS-1:0]   indent_sum;
   logic [TAB_BITS-1:0]   indent_add;
   logic [CNT_BITS-1:0]   count_m1;
   logic [LEVEL_BITS-1:0] rd_level;
   logic [LINE_BITS-1:0]  rd_start;
   logic                  pop_hit, emit_want, emit_ok, emit_stall, fin_stall;
   logic [LINE_BITS:0]    start_p1, line_p1;
   logic [31:0]           start_w, end_w, level_w, line_w;

   assign accept = req_valid && req_ready;
   assign is_nl = req_data.char_byte == CHAR_NEWLINE;
   assign is_ws = (req_data.char_byte == CHAR_SPACE) ||
                  ((req_data.char_byte >= CHAR_TAB) && (req_data.char_byte <= CHAR_WS_LAST));
   assign take = req_data.has_char && !is_nl;
   assign close = (req_data.has_char && is_nl) || req_data.end_of_text;
   assign nb_now = take ? (nonblank_ff || !is_ws) : nonblank_ff;

   assign indent_add = (req_data.char_byte == CHAR_SPACE) ? TAB_BITS'(1) : tab_ff;
   assign indent_sum = SUM_BITS'(indent_ff) + SUM_BITS'(indent_add);

   always_comb begin
      byte_indent = indent_ff;
      byte_leading = leading_ff;
      if (leading_ff) begin
         if ((req_data.char_byte == CHAR_SPACE) || (req_data.char_byte == CHAR_TAB)) begin
            byte_indent = (indent_sum > SUM_BITS'(LEVEL_MAX)) ? LEVEL_MAX
                                                              : indent_sum[LEVEL_BITS-1:0];
         end else begin
            byte_leading = 1'b0;
         end
      end
   end

   assign count_m1 = count_ff - CNT_BITS'(1);
   assign rd_level = ram_rd_data[ENTRY_BITS-1:LINE_BITS];
   assign rd_start = ram_rd_data[LINE_BITS-1:0];
   assign pop_hit = rd_level >= indent_ff;
   assign emit_want = rd_start < line_ff;
   assign emit_ok = !(sts.pend_valid && !sts.out_free);
   assign emit_stall = emit_want && !emit_ok;
   assign fin_stall = (sts.pend_valid || eot_ff) && !sts.out_free;

   assign start_p1 = {1'b0, rd_start} + (LINE_BITS+1)'(1);
   assign line_p1 = {1'b0, line_ff} + (LINE_BITS+1)'(1);
   assign start_w = 32'(start_p1);
   assign line_w = 32'(line_ff);
   assign end_w = (state_ff == ST_FLUSH_CMP) ? 32'(line_p1) : line_w;
   assign level_w = 32'(rd_level);
   assign range_out.range_start = start_w[POS_BITS-1:0];
   assign range_out.range_end = end_w[POS_BITS-1:0];
   assign range_out.guide_level = level_w[GUIDE_BITS-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && close) begin
               state_in = (nb_now && (count_ff != '0)) ? ST_POP_RD : ST_PUSH;
            end
         end
         ST_POP_RD: state_in = ST_POP_CMP;
         ST_POP_CMP: begin
            if (!pop_hit) begin
               state_in = ST_PUSH;
            end else if (!emit_stall) begin
               state_in = (count_ff > CNT_BITS'(1)) ? ST_POP_RD : ST_PUSH;
            end
         end
         ST_PUSH: state_in = eot_ff ? ST_FLUSH_RD : ST_DONE;
         ST_FLUSH_RD: state_in = (count_ff == '0) ? ST_DONE : ST_FLUSH_CMP;
         ST_FLUSH_CMP: begin
            if (!emit_stall) begin
               state_in = ST_FLUSH_RD;
            end
         end
         ST_DONE: begin
            if (!fin_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      count_in = count_ff;
      line_in = line_ff;
      indent_in = indent_ff;
      leading_in = leading_ff;
      nonblank_in = nonblank_ff;
      ovf_in = ovf_ff;
      eot_in = eot_ff;
      nl_in = nl_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = count_ff[ADDR_BITS-1:0];
      ram_wr_data = {indent_ff, line_ff};
      ram_rd_en = 1'b0;
      ram_rd_addr = count_m1[ADDR_BITS-1:0];
      ctl = '0;
      ctl.overflow = ovf_ff;
      ctl.end_text = eot_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (take) begin
                  indent_in = byte_indent;
                  leading_in = byte_leading;
                  nonblank_in = nb_now;
               end
               eot_in = req_data.end_of_text;
               nl_in = req_data.has_char && is_nl;
            end
         end
         ST_POP_RD: ram_rd_en = 1'b1;
         ST_POP_CMP: begin
            if (pop_hit && !emit_stall) begin
               count_in = count_m1;
               ctl.emit = emit_want;
            end
         end
         ST_PUSH: begin
            if (nonblank_ff && (indent_ff != '0)) begin
               if (count_ff < CNT_FULL) begin
                  ram_wr_en = 1'b1;
                  count_in = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            indent_in = '0;
            leading_in = 1'b1;
            nonblank_in = 1'b0;
            if (nl_ff && (line_ff != LINE_LAST)) begin
               line_in = line_ff + LINE_BITS'(1);
            end
         end
         ST_FLUSH_RD: ram_rd_en = count_ff != '0;
         ST_FLUSH_CMP: begin
            if (!emit_stall) begin
               count_in = count_m1;
               ctl.emit = emit_want;
            end
         end
         ST_DONE: begin
            if (!fin_stall) begin
               ctl.finish = 1'b1;
               if (eot_ff) begin
                  count_in = '0;
                  line_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         line_ff <= '0;
         indent_ff <= '0;
         leading_ff <= 1'b1;
         nonblank_ff <= 1'b0;
         ovf_ff <= 1'b0;
         tab_ff <= TAB_RESET;
         eot_ff <= 1'b0;
         nl_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         line_ff <= line_in;
         indent_ff <= indent_in;
         leading_ff <= leading_in;
         nonblank_ff <= nonblank_in;
         ovf_ff <= ovf_in;
         eot_ff <= eot_in;
         nl_ff <= nl_in;
         if (csr_we) begin
            tab_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: hw/rtl/indent_nesting_range_tracker_top.sv
// Top level of the indentation nesting range tracker.
//
// Text bytes enter on the req_ channel (valid/ready), one byte per request,
// with has_char and end_of_text flags. Guide ranges leave on the rsp_
// channel (valid/ready); last_of_run marks the final range of a request.
// csr_we/csr_wdata set the tab width at any idle moment.
//
// A byte that does not end a line is taken while the sequencer is idle.
// A line end after text reads and compares stack entries, popping those
// covered, then pushes the new level; end of text flushes all the rest.
// The stack RAM, read once per pop, has registered read data. Each result
// moves to the output register when the next is found, the last at request end.
// Reset empties the stack, zeroes the line count and sets the tab width
// to 4; no clearing pass is needed. When the receiver stalls, one range
// is held pending and one in the output register, then the sequencer waits.
module indent_nesting_range_tracker_top
   import inrt_pkg::*;
   #(parameter int STACK_DEPTH = 32,
     parameter int MAX_LINES = 65536,
     parameter int LEVEL_BITS = 12)
   (input  logic                clock,
    input  logic                reset,
    input  logic                csr_we,
    input  logic [TAB_BITS-1:0] csr_wdata,
    input  logic                req_valid,
    output logic                req_ready,
    input  req_type             req_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rsp_type             rsp_data);

   localparam int LINE_BITS = $clog2(MAX_LINES);
   localparam int ADDR_BITS = $clog2(STACK_DEPTH);
   localparam int ENTRY_BITS = LEVEL_BITS + LINE_BITS;

   logic                  ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr, ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data, ram_rd_data;
   emit_ctl_type          ctl;
   range_type             range_out;
   stage_sts_type         sts;

   inrt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data));

   inrt_core #(.STACK_DEPTH(STACK_DEPTH), .MAX_LINES(MAX_LINES),
               .LEVEL_BITS(LEVEL_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ctl         (ctl),
      .range_out   (range_out),
      .sts         (sts));

   inrt_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .range_in  (range_out),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data));

endmodule

// File: hw/rtl/inrt_checker.sv
// Port-level checker for the tracker top level, with its bind.
module inrt_checker
   import inrt_pkg::*;
   (input logic    clock,
    input logic    reset,
    input logic    req_valid,
    input logic    req_ready,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input rsp_type rsp_data);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_end_marker |-> rsp_data.last_of_run)
      else $error("end marker not on last result of request");

endmodule

bind indent_nesting_range_tracker_top inrt_checker u_inrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data));

// File: verif/tb_indent_nesting_range_tracker_top.sv
`timescale 1ns / 100ps
// Testbench for the indentation nesting range tracker: text streams checked against a predictor.
module tb_indent_nesting_range_tracker_top;
   import inrt_pkg::*;

   localparam int STACK_DEPTH    = 32;
   localparam int MAX_LINES      = 65536;
   localparam int LEVEL_MAX      = (1 << GUIDE_BITS) - 1;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 500;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                csr_we    = 1'b0;
   logic [TAB_BITS-1:0] csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;

   indent_nesting_range_tracker_top #(
      .STACK_DEPTH(STACK_DEPTH),
      .MAX_LINES(MAX_LINES),
      .LEVEL_BITS(GUIDE_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // predictor state
   logic [TAB_BITS-1:0] tab_cols = TAB_RESET;
   int      guide_levels [STACK_DEPTH];
   int      guide_starts [STACK_DEPTH];
   int      guide_depth   = 0;
   int      line_no       = 0;
   int      indent_cols   = 0;
   bit      in_lead       = 1'b1;
   bit      line_has_text = 1'b0;
   bit      push_dropped  = 1'b0;
   rsp_type run_buf [STACK_DEPTH+2];
   int      run_len;

   rsp_type expected_ranges [$];
   req_type pending_bytes [$];
   rsp_type want_range;

   int err_count     = 0;
   int queued_items  = 0;
   int prev_units    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asks     = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   bit req_taken     = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      err_count++;
   endtask

   task add_range(input int first, input int last, input int level);
      run_buf[run_len] = '0;
      run_buf[run_len].range_start = POS_BITS'(first);
      run_buf[run_len].range_end = POS_BITS'(last);
      run_buf[run_len].guide_level = GUIDE_BITS'(level);
      run_len++;
   endtask

   task close_line();
      if (line_has_text) begin
         while (guide_depth > 0 && guide_levels[guide_depth-1] >= indent_cols) begin
            guide_depth--;
            if (guide_starts[guide_depth] < line_no)
               add_range(guide_starts[guide_depth] + 1, line_no, guide_levels[guide_depth]);
         end
         if (indent_cols > 0) begin
            if (guide_depth < STACK_DEPTH) begin
               guide_levels[guide_depth] = indent_cols;
               guide_starts[guide_depth] = line_no;
               guide_depth++;
            end else begin
               push_dropped = 1'b1;
            end
         end
      end
      indent_cols = 0;
      in_lead = 1'b1;
      line_has_text = 1'b0;
   endtask

   task automatic track_request(input req_type r);
      int add;
      bit ws;
      run_len = 0;
      add = 0;
      ws = (r.char_byte == CHAR_SPACE) ||
           (r.char_byte >= CHAR_TAB && r.char_byte <= CHAR_WS_LAST);
      if (r.has_char) begin
         if (r.char_byte == CHAR_NEWLINE) begin
            close_line();
            if (line_no < MAX_LINES - 1)
               line_no++;
         end else begin
            if (!ws)
               line_has_text = 1'b1;
            if (in_lead) begin
               if (r.char_byte == CHAR_SPACE)
                  add = 1;
               else if (r.char_byte == CHAR_TAB)
                  add = int'(tab_cols);
               else
                  in_lead = 1'b0;
               indent_cols = (indent_cols + add > LEVEL_MAX) ? LEVEL_MAX : indent_cols + add;
            end
         end
      end
      if (r.end_of_text) begin
         close_line();
         while (guide_depth > 0) begin
            guide_depth--;
            if (guide_starts[guide_depth] < line_no)
               add_range(guide_starts[guide_depth] + 1, line_no + 1, guide_levels[guide_depth]);
         end
         if (run_len == 0)
            add_range(0, 0, 0);
         run_buf[run_len-1].is_end_marker = 1'b1;
      end
      for (int k = 0; k < run_len; k++) begin
         run_buf[k].overflow = push_dropped;
         run_buf[k].last_of_run = (k == run_len - 1);
         expected_ranges.push_back(run_buf[k]);
      end
      if (r.end_of_text) begin
         guide_depth = 0;
         line_no = 0;
         indent_cols = 0;
         in_lead = 1'b1;
         line_has_text = 1'b0;
         push_dropped = 1'b0;
      end
   endtask

   // request acceptance and prediction
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (req_taken)
         track_request(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ranges.size() == 0) begin
            report_error($sformatf("unexpected range %0d..%0d lvl %0d end %0b ovf %0b last %0b",
               rsp_data.range_start, rsp_data.range_end, rsp_data.guide_level,
               rsp_data.is_end_marker, rsp_data.overflow, rsp_data.last_of_run));
         end else begin
            want_range = expected_ranges.pop_front();
            if (rsp_data !== want_range)
               report_error($sformatf({"got %0d..%0d lvl %0d end %0b ovf %0b last %0b, ",
                  "want %0d..%0d lvl %0d end %0b ovf %0b last %0b"},
                  rsp_data.range_start, rsp_data.range_end, rsp_data.guide_level,
                  rsp_data.is_end_marker, rsp_data.overflow, rsp_data.last_of_run,
                  want_range.range_start, want_range.range_end, want_range.guide_level,
                  want_range.is_end_marker, want_range.overflow, want_range.last_of_run));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL indent_nesting_range_tracker_top");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task push_req(input logic [7:0] c, input bit has, input bit eot);
      req_type r;
      r.char_byte = c;
      r.has_char = has;
      r.end_of_text = eot;
      pending_bytes.push_back(r);
      if (has || eot)
         queued_items++;
   endtask

   task push_line(input int tabs, input int spaces, input logic [7:0] body, input int tail);
      repeat (tabs) push_req(CHAR_TAB, 1'b1, 1'b0);
      repeat (spaces) push_req(CHAR_SPACE, 1'b1, 1'b0);
      push_req(body, 1'b1, 1'b0);
      repeat (tail) push_req(8'($urandom_range(255)), 1'b1, 1'b0);
      push_req(CHAR_NEWLINE, 1'b1, 1'b0);
   endtask

   function automatic logic [7:0] body_byte();
      if ($urandom_range(3) == 0)
         return 8'($urandom_range(255));
      return 8'($urandom_range(33, 126));
   endfunction

   task automatic fill_text(input int n);
      int target;
      int pick;
      int units;
      int tabs;
      logic [7:0] c;
      target = queued_items + n;
      while (queued_items < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            push_req(8'($urandom_range(255)), 1'($urandom_range(1)),
                     $urandom_range(29) == 0);
         end else if (pick < 18) begin
            repeat ($urandom_range(3)) begin
               c = CHAR_TAB + 8'($urandom_range(4));
               if (c == CHAR_NEWLINE)
                  c = CHAR_SPACE;
               push_req(c, 1'b1, 1'b0);
            end
            push_req(CHAR_NEWLINE, 1'b1, 1'b0);
         end else if (pick < 21) begin
            if ($urandom_range(1))
               push_req(body_byte(), 1'b1, 1'b1);
            else
               push_req(8'($urandom_range(255)), 1'b0, 1'b1);
            prev_units = 0;
         end else begin
            units = prev_units + $urandom_range(4) - 2;
            if (units < 0)
               units = 0;
            if (units > 12)
               units = 12;
            prev_units = units;
            tabs = $urandom_range(units);
            push_line(tabs, units - tabs, body_byte(), $urandom_range(2));
         end
      end
   endtask

   task write_tab(input logic [TAB_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      tab_cols = value;
   endtask

   task set_pace(input int send_pct, input int stall_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task wait_drained();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_ranges.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed text at the reset tab width
      set_pace(0, 0);
      push_req(8'($urandom_range(255)), 1'b0, 1'b0);
      push_line(1, 0, "a", 0);
      push_req(CHAR_SPACE, 1'b1, 1'b0);
      push_req(CHAR_WS_LAST, 1'b1, 1'b0);
      push_req(CHAR_SPACE, 1'b1, 1'b0);
      push_req(CHAR_NEWLINE, 1'b1, 1'b0);
      push_req(8'd11, 1'b1, 1'b0);
      push_req(8'd12, 1'b1, 1'b0);
      push_req(CHAR_NEWLINE, 1'b1, 1'b0);
      push_line(0, 0, 8'h00, 0);
      push_req(CHAR_SPACE, 1'b1, 1'b0);
      push_req(8'hFF, 1'b1, 1'b1);
      push_req(8'($urandom_range(255)), 1'b0, 1'b1);
      push_req(CHAR_SPACE, 1'b1, 1'b0);
      push_req("q", 1'b1, 1'b0);
      push_req(CHAR_NEWLINE, 1'b1, 1'b1);
      wait_drained();

      write_tab(5'd1);
      set_pace(0, 0);
      fill_text(25);
      wait_drained();

      write_tab(5'd16);
      set_pace(85, 0);
      fill_text(25);
      wait_drained();

      write_tab(5'd0);
      set_pace(0, 85);
      fill_text(25);
      wait_drained();

      // saturating indent at the widest tab
      write_tab(5'd31);
      set_pace(23, 23);
      fill_text(25);
      push_line(135, 2, "x", 0);
      push_line(1, 0, "y", 0);
      wait_drained();

      // long receiver hold-off while requests keep coming
      write_tab(5'd2);
      set_pace(0, 0);
      fill_text(40);
      hold_asks++;
      wait_drained();

      // staircase deeper than the stack
      write_tab(5'd5);
      set_pace(0, 0);
      push_req(8'($urandom_range(255)), 1'b0, 1'b1);
      for (int k = 1; k <= STACK_DEPTH + 2; k++)
         push_line(k / 5, k % 5, "x", 0);
      push_req(8'($urandom_range(255)), 1'b0, 1'b1);
      wait_drained();

      if (err_count == 0 && expected_ranges.size() == 0)
         $display("PASS indent_nesting_range_tracker_top");
      else
         $display("FAIL indent_nesting_range_tracker_top");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/inrt_pkg.sv
hw/rtl/inrt_ram.sv
hw/rtl/inrt_out_stage.sv
hw/rtl/inrt_core.sv
hw/rtl/indent_nesting_range_tracker_top.sv
hw/rtl/inrt_checker.sv
verif/tb_indent_nesting_range_tracker_top.sv
